// ----- design/rtc_am_pkg.sv -----
// Shared types, codes and calendar helpers for the RTC alarm matcher.
`default_nettype none

package rtc_am_pkg;

    // Command codes of an input item
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // Repeat modes
    localparam logic [2:0] MODE_ONESHOT = 3'd0;
    localparam logic [2:0] MODE_DAILY   = 3'd1;
    localparam logic [2:0] MODE_WEEKLY  = 3'd2;
    localparam logic [2:0] MODE_MONTHLY = 3'd3;
    localparam logic [2:0] MODE_YEARLY  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_SEC  = 3'd0;
    localparam logic [2:0] REG_MIN  = 3'd1;
    localparam logic [2:0] REG_HOUR = 3'd2;
    localparam logic [2:0] REG_WDAY = 3'd3;
    localparam logic [2:0] REG_MDAY = 3'd4;
    localparam logic [2:0] REG_MON  = 3'd5;
    localparam logic [2:0] REG_YEAR = 3'd6;
    localparam logic [2:0] REG_MODE = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [5:0] WAKE_WINDOW = 6'd2;
    localparam int         DAYCNT_W    = 20;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] now_sec;
        logic [5:0] now_min;
        logic [4:0] now_hour;
        logic [2:0] now_wday;
        logic [4:0] now_mday;
        logic [3:0] now_mon;
        logic [7:0] now_year;
    } t_in_item;

    typedef struct packed {
        logic wakeup;
        logic armed_out;
    } t_out_item;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [2:0] wday;
        logic [4:0] mday;
        logic [3:0] mon;
        logic [7:0] year;
        logic [2:0] mode;
    } t_alarm;

    // Seconds of day without range checks; fits 17 bits for any field pattern
    function automatic logic [16:0] day_seconds(input logic [5:0] s,
                                                input logic [5:0] m,
                                                input logic [4:0] h);
        day_seconds = 17'(s) + 17'(m) * 17'd60 + 17'(h) * 17'd3600;
    endfunction

    // Days before the month, year starting in March: (153*mp+2)/5
    function automatic logic [8:0] month_days(input logic [3:0] mp);
        case (mp)
            4'd0:    month_days = 9'd0;
            4'd1:    month_days = 9'd31;
            4'd2:    month_days = 9'd61;
            4'd3:    month_days = 9'd92;
            4'd4:    month_days = 9'd122;
            4'd5:    month_days = 9'd153;
            4'd6:    month_days = 9'd184;
            4'd7:    month_days = 9'd214;
            4'd8:    month_days = 9'd245;
            4'd9:    month_days = 9'd275;
            4'd10:   month_days = 9'd306;
            4'd11:   month_days = 9'd337;
            default: month_days = 9'd0;
        endcase
    endfunction

    // Gregorian day number with a fixed offset; y stays within 1899..2156
    function automatic logic [DAYCNT_W-1:0] day_count(input logic [7:0] year,
                                                      input logic [3:0] mon,
                                                      input logic [4:0] mday);
        logic        roll;
        logic [3:0]  m;
        logic [3:0]  mp;
        logic [11:0] y;
        logic [4:0]  q100;
        logic [2:0]  q400;
        roll = (mon >= 4'd12);
        m    = roll ? (mon - 4'd11) : (mon + 4'd1);
        y    = 12'd1900 + 12'(year) + 12'(roll) - 12'(m <= 4'd2);
        mp   = (m >= 4'd3) ? (m - 4'd3) : (m + 4'd9);
        // Quotients by 100 and 400 over the narrow span of y
        if (y >= 12'd2100) begin
            q100 = 5'd21;
        end else if (y >= 12'd2000) begin
            q100 = 5'd20;
        end else if (y >= 12'd1900) begin
            q100 = 5'd19;
        end else begin
            q100 = 5'd18;
        end
        q400 = (y >= 12'd2000) ? 3'd5 : 3'd4;
        day_count = DAYCNT_W'(y) * DAYCNT_W'(365) + DAYCNT_W'(y >> 2)
                  - DAYCNT_W'(q100) + DAYCNT_W'(q400)
                  + DAYCNT_W'(month_days(mp)) + DAYCNT_W'(mday);
    endfunction

endpackage

`default_nettype wire

// ----- design/rtc_alarm_matcher.sv -----
// Top level of the RTC alarm matcher: input register, compare logic, result register.
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries commands: a time tick
//   with the current calendar time, a start that arms the alarm, or a stop.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns one result per
//   command: the wake pulse and the armed flag after that command.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   writes the alarm registers; it is always ready. Write only while the block is idle.
// Timing:
//   A command transferred into the input register moves through the compare logic into
//   the result register once that register is free, and its result transfers from there.
//   Throughput is one command per cycle unless the receiver stalls; the input and the
//   result register each hold one item, and the compare between them is a single pass.
//   When the receiver stalls, the result register holds and the input register still
//   takes one more command; o_in_stall rises only when both registers are full.
// Reset:
//   Synchronous, active low. Clears both valid flags and the armed flag, and returns
//   the alarm registers to 00:00:00, day 1, January, year 0, daily mode.
`default_nettype none

module rtc_alarm_matcher (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  rtc_am_pkg::t_in_item                 i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output rtc_am_pkg::t_out_item                o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rtc_am_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rtc_am_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import rtc_am_pkg::*;

    t_alarm    r_alarm;
    t_in_item  r_in;
    logic      r_in_vld;
    t_out_item r_out;
    logic      r_out_vld;
    logic      r_armed;
    t_out_item n_out;
    logic      out_free;
    logic      s_adv;
    logic      in_take;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_vld || !i_out_stall;
    assign s_adv       = r_in_vld && out_free;
    assign o_in_stall  = r_in_vld && !out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    rtc_am_match u_match (
        .i_alarm  (r_alarm),
        .i_item   (r_in),
        .i_armed  (r_armed),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm.sec  <= 6'd0;
            r_alarm.min  <= 6'd0;
            r_alarm.hour <= 5'd0;
            r_alarm.wday <= 3'd0;
            r_alarm.mday <= 5'd1;
            r_alarm.mon  <= 4'd0;
            r_alarm.year <= 8'd0;
            r_alarm.mode <= MODE_DAILY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SEC:  r_alarm.sec  <= i_cfg_data[5:0];
                REG_MIN:  r_alarm.min  <= i_cfg_data[5:0];
                REG_HOUR: r_alarm.hour <= i_cfg_data[4:0];
                REG_WDAY: r_alarm.wday <= i_cfg_data[2:0];
                REG_MDAY: r_alarm.mday <= i_cfg_data[4:0];
                REG_MON:  r_alarm.mon  <= i_cfg_data[3:0];
                REG_YEAR: r_alarm.year <= i_cfg_data[7:0];
                REG_MODE: r_alarm.mode <= i_cfg_data[2:0];
                default:  r_alarm.mode <= r_alarm.mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_armed   <= 1'b0;
        end else begin
            // Input register refills when empty or when its item moves on
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (s_adv) begin
                r_in_vld <= 1'b0;
            end
            if (s_adv) begin
                r_out_vld <= 1'b1;
                r_armed   <= n_out.armed_out;
            end else if (out_free) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (s_adv) begin
            r_out <= n_out;
        end
    end

    // A stop that moves through the compare stage leaves the alarm disarmed
    a_stop_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv && r_in.cmd == CMD_STOP |=> !r_armed)
        else $error("armed flag set after stop command");

    // A start that moves through the compare stage arms the alarm
    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv && r_in.cmd == CMD_START |=> r_armed)
        else $error("armed flag clear after start command");

    // Input stalls only with both registers full and the receiver stalling
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // The result register always mirrors the armed flag it left behind
    a_out_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv |=> (o_out_data.armed_out == r_armed))
        else $error("result armed flag differs from state");

endmodule

`default_nettype wire

// ----- design/rtc_am_match.sv -----
// Alarm compare logic: one item against the alarm time in the selected repeat mode.
`default_nettype none

module rtc_am_match (
    input  rtc_am_pkg::t_alarm    i_alarm,
    input  rtc_am_pkg::t_in_item  i_item,
    input  logic                  i_armed,
    output rtc_am_pkg::t_out_item o_result
);
    import rtc_am_pkg::*;

    localparam logic signed [23:0] SECS_PER_DAY = 24'sd86400;

    logic [5:0]                 alarm_s;
    logic [16:0]                sod_a;
    logic [16:0]                sod_n;
    logic signed [17:0]         sod_diff;
    logic [DAYCNT_W-1:0]        dc_a;
    logic [DAYCNT_W-1:0]        dc_n;
    logic signed [DAYCNT_W:0]   dc_diff;
    logic                       dc_near;
    logic signed [3:0]          day_off;
    logic signed [23:0]         diff;
    logic                       in_win;
    logic                       hit;

    always_comb begin
        // End of day alarm moves one second early
        if (i_alarm.hour == 5'd23 && i_alarm.min == 6'd59 && i_alarm.sec == 6'd59) begin
            alarm_s = 6'd60 - WAKE_WINDOW;
        end else begin
            alarm_s = i_alarm.sec;
        end
        sod_a    = day_seconds(alarm_s, i_alarm.min, i_alarm.hour);
        sod_n    = day_seconds(i_item.now_sec, i_item.now_min, i_item.now_hour);
        sod_diff = $signed({1'b0, sod_n}) - $signed({1'b0, sod_a});

        dc_a    = day_count(i_alarm.year, i_alarm.mon, i_alarm.mday);
        dc_n    = day_count(i_item.now_year, i_item.now_mon, i_item.now_mday);
        dc_diff = $signed({1'b0, dc_n}) - $signed({1'b0, dc_a});
        // Seconds of day stay below 2^17, so only a day gap within two can match
        dc_near = (dc_diff >= -(DAYCNT_W+1)'(2)) && (dc_diff <= (DAYCNT_W+1)'(2));

        case (i_alarm.mode)
            MODE_ONESHOT: day_off = dc_diff[3:0];
            MODE_WEEKLY:  day_off = $signed({1'b0, i_item.now_wday})
                                  - $signed({1'b0, i_alarm.wday});
            default:      day_off = 4'sd0;
        endcase

        diff   = 24'(day_off) * SECS_PER_DAY + 24'(sod_diff);
        in_win = (diff >= 24'sd0) && (diff <= $signed(24'(WAKE_WINDOW)));

        case (i_alarm.mode)
            MODE_ONESHOT: hit = dc_near && in_win;
            MODE_DAILY:   hit = in_win;
            MODE_WEEKLY:  hit = in_win;
            MODE_MONTHLY: hit = (i_alarm.mday == i_item.now_mday) && in_win;
            MODE_YEARLY:  hit = (i_alarm.mday == i_item.now_mday)
                              && (i_alarm.mon == i_item.now_mon) && in_win;
            default:      hit = 1'b0;
        endcase

        o_result.wakeup    = 1'b0;
        o_result.armed_out = i_armed;
        case (i_item.cmd)
            CMD_START: o_result.armed_out = 1'b1;
            CMD_STOP:  o_result.armed_out = 1'b0;
            CMD_TICK: begin
                if (i_armed && hit) begin
                    o_result.wakeup = 1'b1;
                    // One-shot disarms itself on firing
                    if (i_alarm.mode == MODE_ONESHOT) begin
                        o_result.armed_out = 1'b0;
                    end
                end
            end
            default: o_result.armed_out = i_armed;
        endcase
    end

endmodule

`default_nettype wire

// ----- dv/rtc_alarm_matcher_check.sv -----
// Scoreboard for the RTC alarm matcher: predicts every result and checks the output channel.
module rtc_alarm_matcher_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  rtc_am_pkg::t_in_item                i_in_data,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  rtc_am_pkg::t_out_item               i_out_data,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [rtc_am_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rtc_am_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                  o_fail_cnt,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rtc_am_pkg::*;

    localparam longint SECS_PER_DAY = 86400;
    localparam longint WAKE_SPAN    = 2;
    localparam int     MAX_REPORTS  = 10;

    t_alarm    alarm_r;
    logic      armed_r;
    t_out_item wake_status_q[$];
    int        n_fail = 0;

    function automatic longint secs_of_day(logic [5:0] s, logic [5:0] m, logic [4:0] h);
        return longint'(s) + 60 * longint'(m) + 3600 * longint'(h);
    endfunction

    // Day number on March-based years; months past December roll into the next year
    function automatic longint greg_days(logic [7:0] yr, logic [3:0] mo, logic [4:0] md);
        longint y;
        longint m;
        longint mp;
        y = 1900 + longint'(yr) + longint'(mo) / 12;
        m = longint'(mo) % 12 + 1;
        if (m <= 2) begin
            y = y - 1;
        end
        mp = (m + 9) % 12;
        return 365 * y + y / 4 - y / 100 + y / 400 + (153 * mp + 2) / 5 + longint'(md);
    endfunction

    task automatic log_fail(string msg);
        n_fail++;
        if (n_fail <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_in_item   it;
        t_out_item  res;
        t_out_item  exp_r;
        logic [5:0] a_sec;
        longint     at;
        longint     nt;
        logic       in_win;
        if (!i_rst_n) begin
            alarm_r      = '0;
            alarm_r.mday = 5'd1;
            alarm_r.mode = MODE_DAILY;
            armed_r      = 1'b0;
            wake_status_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (wake_status_q.size() == 0) begin
                    log_fail($sformatf("result with nothing expected: wakeup %0d armed %0d",
                                       i_out_data.wakeup, i_out_data.armed_out));
                end else begin
                    exp_r = wake_status_q.pop_front();
                    if (exp_r.wakeup !== i_out_data.wakeup ||
                        exp_r.armed_out !== i_out_data.armed_out) begin
                        log_fail($sformatf("expected wakeup %0d armed %0d, got wakeup %0d armed %0d",
                                           exp_r.wakeup, exp_r.armed_out,
                                           i_out_data.wakeup, i_out_data.armed_out));
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SEC:  alarm_r.sec  = i_cfg_data[5:0];
                    REG_MIN:  alarm_r.min  = i_cfg_data[5:0];
                    REG_HOUR: alarm_r.hour = i_cfg_data[4:0];
                    REG_WDAY: alarm_r.wday = i_cfg_data[2:0];
                    REG_MDAY: alarm_r.mday = i_cfg_data[4:0];
                    REG_MON:  alarm_r.mon  = i_cfg_data[3:0];
                    REG_YEAR: alarm_r.year = i_cfg_data[7:0];
                    REG_MODE: alarm_r.mode = i_cfg_data[2:0];
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                it  = i_in_data;
                res = '0;
                case (it.cmd)
                    CMD_START: armed_r = 1'b1;
                    CMD_STOP:  armed_r = 1'b0;
                    CMD_TICK: begin
                        if (armed_r) begin
                            // Last second of the day is pulled back so the window fits the day
                            a_sec = alarm_r.sec;
                            if (alarm_r.hour == 23 && alarm_r.min == 59 && alarm_r.sec == 59) begin
                                a_sec = 6'(60 - WAKE_SPAN);
                            end
                            at = secs_of_day(a_sec, alarm_r.min, alarm_r.hour);
                            nt = secs_of_day(it.now_sec, it.now_min, it.now_hour);
                            if (alarm_r.mode == MODE_ONESHOT) begin
                                at += greg_days(alarm_r.year, alarm_r.mon, alarm_r.mday)
                                      * SECS_PER_DAY;
                                nt += greg_days(it.now_year, it.now_mon, it.now_mday)
                                      * SECS_PER_DAY;
                            end else if (alarm_r.mode == MODE_WEEKLY) begin
                                at += longint'(alarm_r.wday) * SECS_PER_DAY;
                                nt += longint'(it.now_wday) * SECS_PER_DAY;
                            end
                            in_win = (nt >= at) && (nt - at <= WAKE_SPAN);
                            case (alarm_r.mode)
                                MODE_ONESHOT: begin
                                    res.wakeup = in_win;
                                    if (in_win) begin
                                        armed_r = 1'b0;
                                    end
                                end
                                MODE_DAILY, MODE_WEEKLY: res.wakeup = in_win;
                                MODE_MONTHLY: res.wakeup = in_win && (alarm_r.mday == it.now_mday);
                                MODE_YEARLY: res.wakeup = in_win && (alarm_r.mday == it.now_mday)
                                                         && (alarm_r.mon == it.now_mon);
                                default: res.wakeup = 1'b0;
                            endcase
                        end
                    end
                    default: ;
                endcase
                res.armed_out = armed_r;
                wake_status_q.push_back(res);
            end
        end
        o_pending  = wake_status_q.size();
        o_fail_cnt = n_fail;
    end

endmodule

// ----- dv/rtc_alarm_matcher_test.sv -----
// Top of the RTC alarm matcher testbench: clock, reset, stimulus and final verdict.
module rtc_alarm_matcher_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rtc_am_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int N_PHASES     = 30;
    localparam int PHASE_ITEMS  = 50;
    localparam int HOLD_PHASE   = 6;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int     fail_cnt;
    int     pending_cnt;
    int     cycle_cnt  = 0;
    int     burst_left = 0;
    logic   hold_req   = 1'b0;
    t_alarm cur_alarm;

    always #(CLK_PERIOD / 2) clk = ~clk;

    rtc_alarm_matcher u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    rtc_alarm_matcher_check u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending_cnt)
    );

    function automatic t_in_item mk_item(logic [1:0] c, logic [5:0] s, logic [5:0] m,
                                         logic [4:0] h, logic [2:0] wd, logic [4:0] md,
                                         logic [3:0] mo, logic [7:0] yr);
        t_in_item it;
        it.cmd      = c;
        it.now_sec  = s;
        it.now_min  = m;
        it.now_hour = h;
        it.now_wday = wd;
        it.now_mday = md;
        it.now_mon  = mo;
        it.now_year = yr;
        return it;
    endfunction

    function automatic t_alarm mk_alarm(logic [5:0] s, logic [5:0] m, logic [4:0] h,
                                        logic [2:0] wd, logic [4:0] md, logic [3:0] mo,
                                        logic [7:0] yr, logic [2:0] md_sel);
        t_alarm a;
        a.sec  = s;
        a.min  = m;
        a.hour = h;
        a.wday = wd;
        a.mday = md;
        a.mon  = mo;
        a.year = yr;
        a.mode = md_sel;
        return a;
    endfunction

    function automatic t_in_item any_bits(logic [1:0] c);
        logic [63:0] r;
        t_in_item    it;
        r      = {$urandom, $urandom};
        it     = r[$bits(t_in_item)-1:0];
        it.cmd = c;
        return it;
    endfunction

    function automatic t_in_item calendar_tick();
        return mk_item(CMD_TICK, 6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)),
                       5'($urandom_range(0, 23)), 3'($urandom_range(0, 6)),
                       5'($urandom_range(1, 31)), 4'($urandom_range(0, 11)),
                       8'($urandom_range(0, 137)));
    endfunction

    // Tick a few seconds around the alarm, sometimes across midnight or with a date off
    function automatic t_in_item near_alarm_tick(t_alarm a);
        t_in_item it;
        int       d;
        int       tgt;
        it = mk_item(CMD_TICK, a.sec, a.min, a.hour, a.wday, a.mday, a.mon, a.year);
        d  = int'($urandom_range(0, 8)) - 4;
        if ($urandom_range(0, 1) == 0) begin
            it.now_sec = 6'(int'(a.sec) + d);
        end else begin
            tgt = int'(a.sec) + 60 * int'(a.min) + 3600 * int'(a.hour) + d;
            if (tgt < 0) begin
                tgt = 0;
            end
            if (tgt >= 86400 && $urandom_range(0, 1) == 1) begin
                tgt         = tgt - 86400;
                it.now_mday = a.mday + 5'd1;
                it.now_wday = a.wday + 3'd1;
            end
            if (tgt >= 32 * 3600) begin
                tgt = 32 * 3600 - 1;
            end
            it.now_hour = 5'(tgt / 3600);
            it.now_min  = 6'((tgt % 3600) / 60);
            it.now_sec  = 6'(tgt % 60);
        end
        case ($urandom_range(0, 9))
            0: it.now_wday = 3'($urandom_range(0, 7));
            1: it.now_mday = 5'($urandom_range(0, 31));
            2: it.now_mon  = 4'($urandom_range(0, 15));
            3: it.now_year = 8'($urandom_range(0, 255));
            default: ;
        endcase
        return it;
    endfunction

    // Offer one item; bursts run back to back, gaps drop valid for a few cycles
    task automatic send_item(t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid = 1'b1;
        in_data  = it;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic end_phase();
        in_valid   = 1'b0;
        burst_left = 0;
    endtask

    // Upper data bits beyond the register width carry junk
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value, int width);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value | (8'($urandom_range(0, 255)) << width);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic write_alarm(t_alarm a);
        while (pending_cnt != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        write_reg(REG_SEC,  8'(a.sec),  6);
        write_reg(REG_MIN,  8'(a.min),  6);
        write_reg(REG_HOUR, 8'(a.hour), 5);
        write_reg(REG_WDAY, 8'(a.wday), 3);
        write_reg(REG_MDAY, 8'(a.mday), 5);
        write_reg(REG_MON,  8'(a.mon),  4);
        write_reg(REG_YEAR, a.year,     8);
        write_reg(REG_MODE, 8'(a.mode), 3);
        cfg_valid = 1'b0;
        cur_alarm = a;
    endtask

    // Output stall: changing patterns, plus one long hold-off on request
    initial begin : receiver
        int style;
        int left;
        style     = 0;
        left      = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (left == 0) begin
                style = $urandom_range(0, 3);
                left  = $urandom_range(16, 96);
            end
            left--;
            case (style)
                0: out_stall = 1'b0;
                1: out_stall = 1'($urandom_range(0, 1));
                2: out_stall = ($urandom_range(0, 9) != 0);
                default: out_stall = ~out_stall;
            endcase
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        t_alarm   a;
        t_in_item it;
        int       r;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        cur_alarm      = '0;
        cur_alarm.mday = 5'd1;
        cur_alarm.mode = MODE_DAILY;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset alarm: daily at midnight
        send_item(mk_item(CMD_TICK, 0, 0, 0, 0, 1, 0, 0));
        send_item(mk_item(CMD_UNUSED, 0, 0, 0, 0, 1, 0, 0));
        send_item(mk_item(CMD_START, 0, 0, 0, 0, 1, 0, 0));
        send_item(mk_item(CMD_UNUSED, 63, 63, 31, 7, 31, 15, 255));
        send_item(mk_item(CMD_TICK, 0, 0, 0, 0, 1, 0, 0));
        send_item(mk_item(CMD_TICK, 2, 0, 0, 0, 1, 0, 0));
        send_item(mk_item(CMD_TICK, 3, 0, 0, 0, 1, 0, 0));
        send_item(mk_item(CMD_TICK, 63, 63, 31, 7, 31, 15, 255));
        send_item(mk_item(CMD_STOP, 0, 0, 0, 0, 1, 0, 0));
        send_item(mk_item(CMD_TICK, 0, 0, 0, 0, 1, 0, 0));
        end_phase();

        // End of day alarm fires one second early
        write_alarm(mk_alarm(59, 59, 23, 0, 1, 0, 0, MODE_DAILY));
        send_item(mk_item(CMD_START, 0, 0, 0, 0, 1, 0, 0));
        send_item(mk_item(CMD_TICK, 58, 59, 23, 0, 1, 0, 0));
        send_item(mk_item(CMD_TICK, 57, 59, 23, 0, 1, 0, 0));
        end_phase();

        // One-shot across the new year, month 12 rolling into January, then self disarm
        write_alarm(mk_alarm(59, 59, 23, 0, 31, 11, 137, MODE_ONESHOT));
        send_item(mk_item(CMD_START, 0, 0, 0, 0, 1, 0, 0));
        send_item(mk_item(CMD_TICK, 0, 0, 0, 5, 1, 12, 137));
        send_item(mk_item(CMD_TICK, 0, 0, 0, 5, 1, 12, 137));
        send_item(mk_item(CMD_START, 0, 0, 0, 0, 1, 0, 0));
        send_item(mk_item(CMD_TICK, 0, 0, 0, 5, 1, 0, 138));
        end_phase();

        // Unknown mode arms but never fires
        write_alarm(mk_alarm(59, 59, 23, 0, 31, 11, 137, MODE_UNUSED));
        send_item(mk_item(CMD_START, 0, 0, 0, 0, 1, 0, 0));
        send_item(mk_item(CMD_TICK, 58, 59, 23, 0, 31, 11, 137));
        end_phase();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 0) begin
                a = mk_alarm(0, 0, 0, 0, 1, 0, 0, MODE_ONESHOT);
            end else if (p == 1) begin
                a = mk_alarm(59, 59, 23, 6, 31, 11, 137, MODE_ONESHOT);
            end else if (p == 2) begin
                a = mk_alarm(63, 63, 31, 7, 31, 15, 255, MODE_ONESHOT);
            end else if (p == 3) begin
                a = mk_alarm(59, 59, 23, 3'($urandom_range(0, 6)), 5'($urandom_range(1, 31)),
                             4'($urandom_range(0, 11)), 8'($urandom_range(0, 137)),
                             MODE_ONESHOT);
            end else if ($urandom_range(0, 6) == 0) begin
                a = mk_alarm(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                             5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                             5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                             8'($urandom_range(0, 255)), MODE_ONESHOT);
            end else begin
                a = mk_alarm(6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)),
                             5'($urandom_range(0, 23)), 3'($urandom_range(0, 6)),
                             5'($urandom_range(1, 31)), 4'($urandom_range(0, 11)),
                             8'($urandom_range(0, 137)), MODE_ONESHOT);
            end
            a.mode = (p >= 26) ? 3'($urandom_range(0, 7)) : 3'(p % 5);
            write_alarm(a);
            if (p == HOLD_PHASE) begin
                hold_req = 1'b1;
            end
            send_item(any_bits(CMD_START));
            for (int k = 1; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    it = any_bits(CMD_START);
                end else if (r < 9) begin
                    it = any_bits(CMD_STOP);
                end else if (r < 12) begin
                    it = any_bits(CMD_UNUSED);
                end else if (r < 22) begin
                    it = any_bits(CMD_TICK);
                end else if (r < 30) begin
                    it = calendar_tick();
                end else begin
                    it = near_alarm_tick(cur_alarm);
                end
                send_item(it);
            end
            end_phase();
        end

        while (pending_cnt != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- rtc_alarm_matcher.f -----
design/rtc_am_pkg.sv
design/rtc_am_match.sv
design/rtc_alarm_matcher.sv
dv/rtc_alarm_matcher_check.sv
dv/rtc_alarm_matcher_test.sv
